// ----- src/lodls_pkg.sv -----
// ----------------------------------------------------------------------------
// lodls_pkg
// Shared types and constants for the detail-level selector.
// ----------------------------------------------------------------------------
package lodls_pkg;

  localparam int unsigned DIST_W   = 24;  // unsigned 16.8 metres
  localparam int unsigned LEVEL_W  = 3;
  localparam int unsigned NUM_THR  = 6;   // threshold_level1..6
  localparam int unsigned APB_AW   = 5;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 8;

  // Register indexes (byte address 4*index)
  localparam logic [2:0] REG_LEVEL_COUNT = 3'd0;
  localparam logic [2:0] REG_HYST_BAND   = 3'd1;
  localparam logic [2:0] REG_THR_LEVEL1  = 3'd2;
  localparam logic [2:0] REG_THR_LEVEL2  = 3'd3;
  localparam logic [2:0] REG_THR_LEVEL3  = 3'd4;
  localparam logic [2:0] REG_THR_LEVEL4  = 3'd5;
  localparam logic [2:0] REG_THR_LEVEL5  = 3'd6;
  localparam logic [2:0] REG_THR_LEVEL6  = 3'd7;

  localparam logic [LEVEL_W-1:0] LEVEL_COUNT_RESET = 3'd1;

  // Configuration seen by the datapath; thr[k] is threshold_level(k+1)
  typedef struct packed {
    logic [LEVEL_W-1:0]                level_count;
    logic [DIST_W-1:0]                 hysteresis_band;
    logic [NUM_THR-1:0][DIST_W-1:0]    thr;
  } cfg_t;

endpackage

// ----- src/lodls_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// lodls_cfg_regs
// APB register file: level count, hysteresis band and six thresholds.
// ----------------------------------------------------------------------------
module lodls_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lodls_pkg::APB_AW-1:0]        paddr,
  input  logic [lodls_pkg::APB_DW-1:0]        pwdata,
  output logic [lodls_pkg::APB_DW-1:0]        prdata,
  output logic                                pready,
  output lodls_pkg::cfg_t                     cfg
);

  logic [lodls_pkg::LEVEL_W-1:0] level_count;
  logic [lodls_pkg::DIST_W-1:0]  hysteresis_band;
  logic [lodls_pkg::NUM_THR-1:0][lodls_pkg::DIST_W-1:0] thr;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_count     <= lodls_pkg::LEVEL_COUNT_RESET;
      hysteresis_band <= '0;
      thr             <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        lodls_pkg::REG_LEVEL_COUNT: level_count     <= pwdata[lodls_pkg::LEVEL_W-1:0];
        lodls_pkg::REG_HYST_BAND:   hysteresis_band <= pwdata[lodls_pkg::DIST_W-1:0];
        lodls_pkg::REG_THR_LEVEL1:  thr[0] <= pwdata[lodls_pkg::DIST_W-1:0];
        lodls_pkg::REG_THR_LEVEL2:  thr[1] <= pwdata[lodls_pkg::DIST_W-1:0];
        lodls_pkg::REG_THR_LEVEL3:  thr[2] <= pwdata[lodls_pkg::DIST_W-1:0];
        lodls_pkg::REG_THR_LEVEL4:  thr[3] <= pwdata[lodls_pkg::DIST_W-1:0];
        lodls_pkg::REG_THR_LEVEL5:  thr[4] <= pwdata[lodls_pkg::DIST_W-1:0];
        lodls_pkg::REG_THR_LEVEL6:  thr[5] <= pwdata[lodls_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      lodls_pkg::REG_LEVEL_COUNT: prdata = 32'(level_count);
      lodls_pkg::REG_HYST_BAND:   prdata = 32'(hysteresis_band);
      lodls_pkg::REG_THR_LEVEL1:  prdata = 32'(thr[0]);
      lodls_pkg::REG_THR_LEVEL2:  prdata = 32'(thr[1]);
      lodls_pkg::REG_THR_LEVEL3:  prdata = 32'(thr[2]);
      lodls_pkg::REG_THR_LEVEL4:  prdata = 32'(thr[3]);
      lodls_pkg::REG_THR_LEVEL5:  prdata = 32'(thr[4]);
      lodls_pkg::REG_THR_LEVEL6:  prdata = 32'(thr[5]);
      default:                    prdata = '0;
    endcase
  end

  assign cfg.level_count     = level_count;
  assign cfg.hysteresis_band = hysteresis_band;
  assign cfg.thr             = thr;

endmodule

// ----- src/lodls_select.sv -----
// ----------------------------------------------------------------------------
// lodls_select
// Threshold selection and hysteresis decision for one query.
// ----------------------------------------------------------------------------
module lodls_select #(
  parameter int unsigned MAX_LEVELS = 7
) (
  input  lodls_pkg::cfg_t                     cfg,
  input  logic [lodls_pkg::DIST_W-1:0]        viewer_distance,
  input  logic [lodls_pkg::LEVEL_W-1:0]       prior_level,
  output logic [lodls_pkg::LEVEL_W-1:0]       chosen_level
);

  localparam logic [lodls_pkg::LEVEL_W-1:0] MaxLv = lodls_pkg::LEVEL_W'(MAX_LEVELS);

  // Thresholds by level number; level 0 and the unused top slot read zero
  logic [lodls_pkg::DIST_W-1:0] thr_lv [0:(1 << lodls_pkg::LEVEL_W)-1];
  logic [lodls_pkg::LEVEL_W-1:0] cnt;
  logic [lodls_pkg::LEVEL_W-1:0] sel;
  logic [lodls_pkg::DIST_W:0]    upper_edge;
  logic signed [lodls_pkg::DIST_W:0] lower_edge;
  logic hyst_on;
  logic keep_coarse;
  logic keep_fine;

  always_comb begin
    for (int k = 0; k < (1 << lodls_pkg::LEVEL_W); k++) begin
      thr_lv[lodls_pkg::LEVEL_W'(k)] = '0;
    end
    for (int k = 1; k <= int'(lodls_pkg::NUM_THR); k++) begin
      thr_lv[lodls_pkg::LEVEL_W'(k)] = cfg.thr[lodls_pkg::LEVEL_W'(k-1)];
    end
  end

  // Clamp the level count to 1..MAX_LEVELS
  always_comb begin
    if (cfg.level_count == '0) begin
      cnt = lodls_pkg::LEVEL_W'(1);
    end else if (cfg.level_count > MaxLv) begin
      cnt = MaxLv;
    end else begin
      cnt = cfg.level_count;
    end
  end

  // Last matching level wins
  always_comb begin
    sel = '0;
    for (int k = 1; k <= int'(lodls_pkg::NUM_THR); k++) begin
      if ((lodls_pkg::LEVEL_W'(k) < cnt) &&
          (viewer_distance >= thr_lv[lodls_pkg::LEVEL_W'(k)])) begin
        sel = lodls_pkg::LEVEL_W'(k);
      end
    end
  end

  // Band edges one bit wider: upper never wraps, lower may go negative
  assign upper_edge = {1'b0, thr_lv[sel]} + {1'b0, cfg.hysteresis_band};
  assign lower_edge = $signed({1'b0, thr_lv[prior_level]})
                    - $signed({1'b0, cfg.hysteresis_band});

  assign hyst_on     = (prior_level < cnt) && (prior_level != sel) &&
                       (cfg.hysteresis_band != '0);
  assign keep_coarse = ({1'b0, viewer_distance} < upper_edge);
  assign keep_fine   = ($signed({1'b0, viewer_distance}) > lower_edge);

  always_comb begin
    chosen_level = sel;
    if (hyst_on) begin
      if (prior_level < sel) begin
        if (keep_coarse) begin
          chosen_level = prior_level;
        end
      end else begin
        if (keep_fine) begin
          chosen_level = prior_level;
        end
      end
    end
  end

endmodule

// ----- src/lod_level_select_hysteresis.sv -----
// ----------------------------------------------------------------------------
// lod_level_select_hysteresis
// Picks a detail level from a viewer distance, with hysteresis around the
// level boundaries so an object does not flicker between levels.
// ----------------------------------------------------------------------------
//
//  Channel  Dir   Handshake           Word contents
//  -------  ----  ------------------  ---------------------------------------
//  s_*      in    s_tvalid/s_tready   viewer_distance[23:0], prior_level[26:24]
//  m_*      out   m_tvalid/m_tready   chosen_level[2:0]
//  APB      in    psel/penable        8 registers at byte address 4*index
//
//  Cycles: one query per clock while m_tready holds; a word taken on s_*
//  passes the input register, then the result register, before its result
//  is valid on m_*. The selection runs in one pass of compares between
//  those two registers.
//  Reset (rst, synchronous) empties both stages and loads register defaults.
//  A stall on m_tready holds the result register; the input stage keeps
//  taking words until it is full too, then s_tready drops.
// ----------------------------------------------------------------------------
module lod_level_select_hysteresis #(
  parameter int unsigned MAX_LEVELS = 7
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Query stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [lodls_pkg::IN_TDATA_W-1:0]     s_tdata,   // [23:0] viewer_distance,
                                                          // [26:24] prior_level, rest 0
  // Result stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [lodls_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [2:0] chosen_level, rest 0
  // Configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [lodls_pkg::APB_AW-1:0]         paddr,
  input  logic [lodls_pkg::APB_DW-1:0]         pwdata,
  output logic [lodls_pkg::APB_DW-1:0]         prdata,
  output logic                                 pready
);

  lodls_pkg::cfg_t cfg;

  // Input stage
  logic                              in_valid;
  logic [lodls_pkg::DIST_W-1:0]      in_dist;
  logic [lodls_pkg::LEVEL_W-1:0]     in_prior;
  // Result stage
  logic                              out_valid;
  logic [lodls_pkg::LEVEL_W-1:0]     out_level;
  logic [lodls_pkg::LEVEL_W-1:0]     level_next;
  logic                              advance;
  logic                              take_in;

  lodls_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lodls_select #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_sel (
    .cfg             (cfg),
    .viewer_distance (in_dist),
    .prior_level     (in_prior),
    .chosen_level    (level_next)
  );

  // Move the input stage forward whenever the result register is free or
  // is being drained this cycle.
  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;
  assign take_in  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take_in) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      in_dist  <= s_tdata[lodls_pkg::DIST_W-1:0];
      in_prior <= s_tdata[lodls_pkg::DIST_W +: lodls_pkg::LEVEL_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  // Hold the result while the consumer stalls
  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_level <= level_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = lodls_pkg::OUT_TDATA_W'(out_level);

endmodule

// ----- src/lodls_checker.sv -----
// ----------------------------------------------------------------------------
// lodls_checker
// Port-level checks for the detail-level selector, bound to the top level.
// ----------------------------------------------------------------------------
module lodls_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [lodls_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input logic                               pready
);

  // A stalled result holds its word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed under stall");

  // Reset empties the pipeline and opens the input
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("pipeline not empty after reset");

  // A taken query reaches m_* through the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> ##1 m_tvalid)
    else $error("taken query produced no result");

  // Level never exceeds six, padding stays zero, APB never waits
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] != 3'd7) && (m_tdata[7:3] == 5'd0) && pready)
    else $error("result level out of range");

endmodule

bind lod_level_select_hysteresis lodls_checker u_lodls_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .pready   (pready)
);

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the detail-level selector: queries stream in on
// s_*, chosen levels are checked on m_* against a predictor that tracks the
// register settings. The run walks through several register settings with
// random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lodls_pkg::*;

  localparam int unsigned MAX_LEVELS = 7;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RAND_PHASES = 12;
  localparam int unsigned WORDS_PER_PHASE = 75;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef struct packed {
    logic [LEVEL_W-1:0] prior;
    logic [DIST_W-1:0]  distance;
  } query_t;

  typedef logic [DIST_W-1:0] thr_set_t [1:6];

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [IN_TDATA_W-1:0]   s_tdata = '0;   // [23:0] viewer_distance, [26:24] prior_level
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_tdata;        // [2:0] chosen_level
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [APB_AW-1:0]       paddr = '0;
  logic [APB_DW-1:0]       pwdata = '0;
  logic [APB_DW-1:0]       prdata;
  logic                    pready;

  lod_level_select_hysteresis #(.MAX_LEVELS(MAX_LEVELS)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #10 clk = ~clk;

  // Shadow copy of the register file, starting at the reset defaults
  logic [LEVEL_W-1:0] cfg_count = LEVEL_COUNT_RESET;
  logic [DIST_W-1:0]  cfg_band  = '0;
  thr_set_t           cfg_thr   = '{default: '0};

  query_t             query_backlog[$];   // words waiting to be sent
  logic [LEVEL_W-1:0] level_expect[$];    // chosen levels still owed by the block

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count    = 0;
  int unsigned errors         = 0;

  // Chosen level for one query under the current register settings.
  function automatic logic [LEVEL_W-1:0] predict_level(logic [DIST_W-1:0] distance,
                                                       logic [LEVEL_W-1:0] prior);
    int unsigned cnt;
    int unsigned sel;
    cnt = 32'(cfg_count);
    if (cnt < 1) cnt = 1;
    if (cnt > MAX_LEVELS) cnt = MAX_LEVELS;
    sel = 0;
    // Rising order, last match wins, so unordered thresholds behave too
    for (int unsigned lv = 1; lv < cnt; lv++)
      if (distance >= cfg_thr[lv]) sel = lv;
    if (prior < cnt && prior != sel && cfg_band != 0) begin
      // Band edges in 32-bit signed: the finer edge may go below zero
      if (prior < sel) begin
        if (int'(distance) < int'(cfg_thr[sel]) + int'(cfg_band)) return prior;
      end else if (int'(distance) > int'(cfg_thr[prior]) - int'(cfg_band)) begin
        return prior;
      end
    end
    return sel[LEVEL_W-1:0];
  endfunction

  // Global run limit: a hang in either stream ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d levels still owed", $time, level_expect.size());
      $display("FAIL");
      $finish;
    end
  end

  // Query driver: log the accepted word's expected level, then advance or idle
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready)
        level_expect.push_back(predict_level(s_tdata[23:0], s_tdata[26:24]));
      if (!s_tvalid || s_tready) begin
        if (query_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= {5'b0, query_backlog.pop_front()};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare against the oldest owed level, stall at random
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (level_expect.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, got chosen_level %0d",
                   $time, m_tdata[2:0]);
        end else if (m_tdata[2:0] !== level_expect[0]) begin
          errors++;
          $display("%0t: chosen_level mismatch, expected %0d, got %0d",
                   $time, level_expect[0], m_tdata[2:0]);
          void'(level_expect.pop_front());
        end else begin
          void'(level_expect.pop_front());
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Hold until every queued word is sent and every level has come back;
  // look between edges so the driver's updates have settled
  task automatic wait_idle();
    while (query_backlog.size() != 0 || s_tvalid || level_expect.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup cycle, access cycle, register lands at the access edge
  task automatic write_reg(input logic [2:0] idx, input logic [APB_DW-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_LEVEL_COUNT: cfg_count = val[LEVEL_W-1:0];
      REG_HYST_BAND:   cfg_band  = val[DIST_W-1:0];
      default:         cfg_thr[idx - 1] = val[DIST_W-1:0];
    endcase
  endtask

  task automatic apply_config(input logic [LEVEL_W-1:0] cnt, input logic [DIST_W-1:0] band,
                              input thr_set_t t);
    wait_idle();
    write_reg(REG_LEVEL_COUNT, 32'(cnt));
    write_reg(REG_HYST_BAND, 32'(band));
    write_reg(REG_THR_LEVEL1, 32'(t[1]));
    write_reg(REG_THR_LEVEL2, 32'(t[2]));
    write_reg(REG_THR_LEVEL3, 32'(t[3]));
    write_reg(REG_THR_LEVEL4, 32'(t[4]));
    write_reg(REG_THR_LEVEL5, 32'(t[5]));
    write_reg(REG_THR_LEVEL6, 32'(t[6]));
  endtask

  task automatic push_query(input logic [DIST_W-1:0] distance,
                            input logic [LEVEL_W-1:0] prior);
    query_t q;
    q.distance = distance;
    q.prior    = prior;
    query_backlog.push_back(q);
  endtask

  // Random register setting; the phase number steers it through the extremes
  task automatic random_setup(input int unsigned ph);
    logic [LEVEL_W-1:0] cnt;
    logic [DIST_W-1:0]  band;
    thr_set_t           t;
    int unsigned        acc;
    case (ph % 6)
      0:       cnt = 3'd7;
      1:       cnt = 3'd0;
      2:       cnt = 3'd1;
      default: cnt = 3'($urandom_range(0, 7));
    endcase
    case (ph % 4)
      0:       band = '0;
      1:       band = 24'($urandom_range(1, 24'h1000));
      2:       band = DIST_MAX;
      default: band = 24'($urandom_range(0, 24'hFFFFFF));
    endcase
    // Rising thresholds low or high in the range, or fully scattered
    acc = (ph % 3 == 1) ? $urandom_range(0, 24'hFE0000) : $urandom_range(0, 24'h800);
    for (int k = 1; k <= 6; k++) begin
      if (ph % 3 == 2) begin
        t[k] = 24'($urandom_range(0, 24'hFFFFFF));
      end else begin
        acc += $urandom_range(0, 24'h4000);
        t[k] = (acc > DIST_MAX) ? DIST_MAX : acc[DIST_W-1:0];
      end
    end
    if (ph == 5) begin
      t[1] = '0;
      t[6] = DIST_MAX;
    end
    apply_config(cnt, band, t);
  endtask

  // Distances cluster on thresholds and band edges, with noise and extremes
  function automatic query_t random_query();
    query_t      q;
    int          k;
    int          d;
    int          span;
    int unsigned eff;
    eff  = (cfg_count == '0) ? 1 : 32'(cfg_count);
    k    = int'($urandom_range(1, 6));
    span = int'((cfg_band > 24'h10000) ? 24'h10000 : cfg_band) + 16;
    case ($urandom_range(0, 9))
      0, 1, 2: d = int'(cfg_thr[k]) + int'($urandom_range(0, 2 * span)) - span;
      3:       d = int'(cfg_thr[k]) + int'(cfg_band) + int'($urandom_range(0, 2)) - 1;
      4:       d = int'(cfg_thr[k]) - int'(cfg_band) + int'($urandom_range(0, 2)) - 1;
      5:       d = $urandom_range(0, 1) ? 0 : int'(DIST_MAX);
      default: d = int'($urandom_range(0, 24'hFFFFFF));
    endcase
    if (d < 0) d = 0;
    if (d > int'(DIST_MAX)) d = int'(DIST_MAX);
    q.distance = d[DIST_W-1:0];
    // Mostly a valid prior level, sometimes any value including invalid ones
    if ($urandom_range(0, 3) != 0) q.prior = 3'($urandom_range(0, eff - 1));
    else q.prior = 3'($urandom_range(0, 7));
    return q;
  endfunction

  initial begin
    thr_set_t t;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct  = 21;
    recv_stall_pct = 61;

    // Zero level count acts as one level: always the finest level
    apply_config(3'd0, DIST_MAX, '{default: '0});
    push_query('0, 3'd0);
    push_query(DIST_MAX, 3'd7);
    push_query(DIST_MAX, 3'd0);

    // Full level count, rising thresholds 10..60 m, band of 2 m
    t = '{24'd2560, 24'd5120, 24'd7680, 24'd10240, 24'd12800, 24'd15360};
    apply_config(3'd7, 24'd512, t);
    push_query('0, 3'd7);                       // prior at count is ignored
    push_query(t[3], 3'd7);
    push_query(DIST_MAX, 3'd0);
    push_query(t[3], 3'd2);                     // coarser move held back
    push_query(t[3] + 24'd511, 3'd2);
    push_query(t[3] + 24'd512, 3'd2);           // leaves the band
    push_query(t[4] - 24'd1, 3'd4);             // finer move held back
    push_query(t[4] - 24'd511, 3'd4);
    push_query(t[4] - 24'd512, 3'd4);           // leaves the band
    push_query(t[5], 3'd5);

    // Unordered thresholds with a maximal band: finer edge goes negative
    t = '{24'd12800, 24'd2560, 24'd10240, 24'd5120, 24'd0, 24'd0};
    apply_config(3'd5, DIST_MAX, t);
    push_query(24'd7680, 3'd7);
    push_query(24'd7680, 3'd0);
    push_query(24'd1280, 3'd3);
    push_query('0, 3'd4);
    push_query(DIST_MAX, 3'd1);

    // All thresholds at the top of the range
    apply_config(3'd7, '0, '{default: DIST_MAX});
    push_query(DIST_MAX, 3'd2);
    push_query(DIST_MAX - 24'd1, 3'd3);
    push_query('0, 3'd6);

    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      // Swap the idling pattern after the first third, turn idling off for the last
      if (ph == RAND_PHASES / 3) begin
        wait_idle();
        send_idle_pct  = 61;
        recv_stall_pct = 21;
      end else if (ph == 2 * RAND_PHASES / 3) begin
        wait_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      random_setup(ph);
      repeat (WORDS_PER_PHASE) query_backlog.push_back(random_query());
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (level_expect.size() != 0) begin
      errors++;
      $display("%0t: %0d levels never arrived", $time, level_expect.size());
    end
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
